[hdl/ttw_pkg.sv]
// Shared constants, types and helper functions of the texture twiddle writer.
package ttw_pkg;

  localparam int COORD_BITS     = 10;
  localparam int MAX_DIM        = 1 << COORD_BITS;
  localparam int DIM_BITS       = 11;
  localparam int REM_BITS       = 11;
  localparam int WIDE_BITS      = DIM_BITS + 2;
  localparam int OFFSET_BITS    = 2 * COORD_BITS;
  localparam int INDEX_BITS     = 20;
  localparam int BASE_BITS      = 22;
  localparam int ADDR_BITS      = 23;
  localparam int TEXEL_BITS     = 16;
  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 64;
  localparam int OUT_USER_BITS  = 2;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - ADDR_BITS - TEXEL_BITS - INDEX_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 22;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int DIV_STEPS      = DIM_BITS;
  localparam int DIV_COUNT_BITS = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_WIDTH    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_HEIGHT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BASE    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BACKGROUND   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_ENABLE = 3'd6;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TEXEL = 1'b1
  } ttw_kind_t;

  typedef struct packed {
    ttw_kind_t               kind;
    logic [TEXEL_BITS-1:0]   texel;
  } ttw_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   src_width;
    logic [DIM_BITS-1:0]   src_height;
    logic [DIM_BITS-1:0]   dst_width;
    logic [DIM_BITS-1:0]   dst_height;
    logic [BASE_BITS-1:0]  dest_base;
    logic [TEXEL_BITS-1:0] background;
    logic                  scale_enable;
  } ttw_cfg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] col_quo;
    logic [REM_BITS-1:0] col_rem;
    logic [DIM_BITS-1:0] row_quo;
    logic [REM_BITS-1:0] row_rem;
    logic                done;
  } ttw_step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROW,
    ST_READ
  } ttw_state_t;

  function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_BITS'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] twiddle(input logic [COORD_BITS-1:0] x,
                                                     input logic [COORD_BITS-1:0] y);
    logic [OFFSET_BITS-1:0] off;
    off = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      off[2*i]   = y[i];
      off[2*i+1] = x[i];
    end
    return off;
  endfunction

endpackage

[hdl/texture_twiddle_writer.sv]
// Top level of the texture twiddle writer: configuration registers and the front and back parts.
//
// The block scans a destination texture row by row and, for every texel word of a scan,
// gives one write at base plus the Morton offset of the pixel (y in the even bits, x in
// the odd bits) together with the source read index of the next pixel. A start word
// opens a scan and returns the first read index once the 11-step divider has found the
// column and row scale steps. At the end of a destination row a texel word passes an
// extra state, where the source row base is formed by one multiply. Input words are held
// in a four-word queue, and each result waits in an output register, so both sides may
// stall independently. Configuration must be written by the user through the cfg port only
// while no scan word is in flight; the block does not enforce it, cfg_ready is always high.
module texture_twiddle_writer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ttw_pkg::IN_DATA_BITS-1:0]   s_tdata,  // texel
  input  logic                               s_tuser,  // mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // write_address, write_value, read_index, zero pad
  output logic [ttw_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // write_valid, read_valid
  output logic [ttw_pkg::OUT_USER_BITS-1:0]  m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ttw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ttw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  ttw_pkg::ttw_cfg_t   cfg;
  ttw_pkg::ttw_item_t  head;
  ttw_pkg::ttw_step_t  step;
  logic                head_valid;
  logic                pop;
  logic                div_start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width    <= ttw_pkg::DIM_BITS'(1);
      cfg.src_height   <= ttw_pkg::DIM_BITS'(1);
      cfg.dst_width    <= ttw_pkg::DIM_BITS'(1);
      cfg.dst_height   <= ttw_pkg::DIM_BITS'(1);
      cfg.dest_base    <= '0;
      cfg.background   <= '0;
      cfg.scale_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttw_pkg::REG_SRC_WIDTH:    cfg.src_width    <= cfg_data[ttw_pkg::DIM_BITS-1:0];
        ttw_pkg::REG_SRC_HEIGHT:   cfg.src_height   <= cfg_data[ttw_pkg::DIM_BITS-1:0];
        ttw_pkg::REG_DST_WIDTH:    cfg.dst_width    <= cfg_data[ttw_pkg::DIM_BITS-1:0];
        ttw_pkg::REG_DST_HEIGHT:   cfg.dst_height   <= cfg_data[ttw_pkg::DIM_BITS-1:0];
        ttw_pkg::REG_DEST_BASE:    cfg.dest_base    <= cfg_data[ttw_pkg::BASE_BITS-1:0];
        ttw_pkg::REG_BACKGROUND:   cfg.background   <= cfg_data[ttw_pkg::TEXEL_BITS-1:0];
        ttw_pkg::REG_SCALE_ENABLE: cfg.scale_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ttw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  ttw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .cfg   (cfg),
    .step  (step)
  );

  ttw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .div_start  (div_start),
    .step       (step),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[hdl/ttw_front.sv]
// Input side: accepts words, classifies them and queues them for the scan engine.
module ttw_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ttw_pkg::IN_DATA_BITS-1:0] s_tdata,  // texel
  input  logic                             s_tuser,  // mode
  input  logic                             pop,
  output ttw_pkg::ttw_item_t               head,
  output logic                             head_valid
);

  ttw_pkg::ttw_item_t                   queue [ttw_pkg::QUEUE_DEPTH];
  logic [ttw_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [ttw_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [ttw_pkg::QUEUE_PTR_BITS:0]     count;
  logic                                 push;
  logic                                 take;
  ttw_pkg::ttw_item_t                   item;

  assign s_tready   = (count != (ttw_pkg::QUEUE_PTR_BITS+1)'(ttw_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push       = s_tvalid && s_tready;
  assign take       = pop && head_valid;
  assign head       = queue[rd_ptr];

  always_comb begin
    item.kind  = s_tuser ? ttw_pkg::KIND_TEXEL : ttw_pkg::KIND_START;
    item.texel = s_tdata[ttw_pkg::TEXEL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ttw_div.sv]
// Two-lane restoring divider that finds the column and row scale steps at scan start.
module ttw_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ttw_pkg::ttw_cfg_t   cfg,
  output ttw_pkg::ttw_step_t  step
);

  logic                                 busy;
  logic [ttw_pkg::DIV_COUNT_BITS-1:0]   count;
  logic [ttw_pkg::DIM_BITS-1:0]         num_c;
  logic [ttw_pkg::DIM_BITS-1:0]         num_r;
  logic [ttw_pkg::REM_BITS-1:0]         rem_c;
  logic [ttw_pkg::REM_BITS-1:0]         rem_r;
  logic [ttw_pkg::DIM_BITS-1:0]         quo_c;
  logic [ttw_pkg::DIM_BITS-1:0]         quo_r;
  logic                                 done;
  logic [ttw_pkg::DIM_BITS-1:0]         dw;
  logic [ttw_pkg::DIM_BITS-1:0]         dh;
  logic [ttw_pkg::REM_BITS:0]           trial_c;
  logic [ttw_pkg::REM_BITS:0]           trial_r;
  logic                                 fit_c;
  logic                                 fit_r;

  assign dw      = ttw_pkg::eff_dim(cfg.dst_width);
  assign dh      = ttw_pkg::eff_dim(cfg.dst_height);
  assign trial_c = {rem_c, num_c[ttw_pkg::DIM_BITS-1]};
  assign trial_r = {rem_r, num_r[ttw_pkg::DIM_BITS-1]};
  assign fit_c   = trial_c >= (ttw_pkg::REM_BITS+1)'(dw);
  assign fit_r   = trial_r >= (ttw_pkg::REM_BITS+1)'(dh);

  always_comb begin
    step.col_quo = quo_c;
    step.col_rem = rem_c;
    step.row_quo = quo_r;
    step.row_rem = rem_r;
    step.done    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == ttw_pkg::DIV_COUNT_BITS'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= ttw_pkg::DIV_COUNT_BITS'(ttw_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == ttw_pkg::DIV_COUNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_c <= ttw_pkg::eff_dim(cfg.src_width);
      num_r <= ttw_pkg::eff_dim(cfg.src_height);
      rem_c <= '0;
      rem_r <= '0;
      quo_c <= '0;
      quo_r <= '0;
    end else if (busy) begin
      num_c <= num_c << 1;
      num_r <= num_r << 1;
      quo_c <= {quo_c[ttw_pkg::DIM_BITS-2:0], fit_c};
      quo_r <= {quo_r[ttw_pkg::DIM_BITS-2:0], fit_r};
      rem_c <= fit_c ? ttw_pkg::REM_BITS'(trial_c - (ttw_pkg::REM_BITS+1)'(dw))
                     : trial_c[ttw_pkg::REM_BITS-1:0];
      rem_r <= fit_r ? ttw_pkg::REM_BITS'(trial_r - (ttw_pkg::REM_BITS+1)'(dh))
                     : trial_r[ttw_pkg::REM_BITS-1:0];
    end
  end

endmodule

[hdl/ttw_back.sv]
// Scan engine: walks the destination, forms twiddled writes and source reads, holds the result.
module ttw_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ttw_pkg::ttw_cfg_t                 cfg,
  input  ttw_pkg::ttw_item_t                head,
  input  logic                              head_valid,
  output logic                              pop,
  output logic                              div_start,
  input  ttw_pkg::ttw_step_t                step,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // write_address, write_value, read_index, zero pad
  output logic [ttw_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // write_valid, read_valid
  output logic [ttw_pkg::OUT_USER_BITS-1:0] m_tuser,
  output logic                              m_tlast
);

  localparam int CB = ttw_pkg::COORD_BITS;
  localparam int RB = ttw_pkg::REM_BITS;
  localparam int WB = ttw_pkg::WIDE_BITS;
  localparam int PB = ttw_pkg::COORD_BITS + ttw_pkg::DIM_BITS;

  ttw_pkg::ttw_state_t              state;
  ttw_pkg::ttw_state_t              state_next;
  logic                             scan_busy;
  logic [CB-1:0]                    scan_x;
  logic [CB-1:0]                    scan_y;
  logic [CB-1:0]                    source_column;
  logic [CB-1:0]                    source_row;
  logic [RB-1:0]                    column_remainder;
  logic [RB-1:0]                    row_remainder;
  logic [ttw_pkg::INDEX_BITS-1:0]   row_base;

  logic                             hold_write;
  logic [ttw_pkg::ADDR_BITS-1:0]    hold_addr;
  logic [ttw_pkg::TEXEL_BITS-1:0]   hold_value;
  logic                             hold_last;
  logic                             hold_noread;

  logic                             out_valid;
  logic                             out_write;
  logic [ttw_pkg::ADDR_BITS-1:0]    out_addr;
  logic [ttw_pkg::TEXEL_BITS-1:0]   out_value;
  logic                             out_read;
  logic [ttw_pkg::INDEX_BITS-1:0]   out_index;
  logic                             out_last;

  logic [ttw_pkg::DIM_BITS-1:0]     sw;
  logic [ttw_pkg::DIM_BITS-1:0]     sh;
  logic [ttw_pkg::DIM_BITS-1:0]     dw;
  logic [ttw_pkg::DIM_BITS-1:0]     dh;
  logic                             need;
  logic                             end_row;
  logic                             fin;
  logic                             is_start;
  logic                             out_free;
  logic                             out_load;
  logic [ttw_pkg::ADDR_BITS-1:0]    pix_addr;
  logic [CB+RB-1:0]                 col_adv;
  logic [CB+RB-1:0]                 row_adv;
  logic [CB-1:0]                    read_col;
  logic [PB-1:0]                    product;
  logic                             read_ok;

  function automatic logic [CB+RB-1:0] advance(input logic [CB-1:0] coord,
                                                input logic [RB-1:0] rem,
                                                input logic [ttw_pkg::DIM_BITS-1:0] quo,
                                                input logic [RB-1:0] frac,
                                                input logic [ttw_pkg::DIM_BITS-1:0] d);
    logic [RB:0]   s;
    logic          c;
    logic [CB-1:0] nc;
    s = (RB+1)'(rem) + (RB+1)'(frac);
    c = s >= (RB+1)'(d);
    if (c) begin
      s = s - (RB+1)'(d);
    end
    nc = coord + quo[CB-1:0] + CB'(c);
    return {nc, s[RB-1:0]};
  endfunction

  assign sw       = ttw_pkg::eff_dim(cfg.src_width);
  assign sh       = ttw_pkg::eff_dim(cfg.src_height);
  assign dw       = ttw_pkg::eff_dim(cfg.dst_width);
  assign dh       = ttw_pkg::eff_dim(cfg.dst_height);
  assign need     = cfg.scale_enable ||
                    ((WB'(scan_x) < WB'(sw)) && (WB'(scan_y) < WB'(sh)));
  assign end_row  = (WB'(scan_x) + WB'(1)) >= WB'(dw);
  assign fin      = end_row && ((WB'(scan_y) + WB'(1)) >= WB'(dh));
  assign is_start = (head.kind == ttw_pkg::KIND_START);
  assign out_free = !out_valid || m_tready;
  assign pix_addr = ttw_pkg::ADDR_BITS'(cfg.dest_base) +
                    ttw_pkg::ADDR_BITS'(ttw_pkg::twiddle(scan_x, scan_y));
  assign col_adv  = advance(source_column, column_remainder, step.col_quo, step.col_rem, dw);
  assign row_adv  = advance(source_row, row_remainder, step.row_quo, step.row_rem, dh);
  assign read_col = cfg.scale_enable ? source_column : scan_x;
  assign product  = PB'(cfg.scale_enable ? source_row : scan_y) * PB'(sw);
  assign read_ok  = !hold_noread && need;

  always_comb begin
    state_next = state;
    case (state)
      ttw_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (is_start) begin
            state_next = ttw_pkg::ST_DIV;
          end else if (scan_busy && !fin && end_row) begin
            state_next = ttw_pkg::ST_ROW;
          end else begin
            state_next = ttw_pkg::ST_READ;
          end
        end
      end
      ttw_pkg::ST_DIV: begin
        if (step.done) begin
          state_next = ttw_pkg::ST_READ;
        end
      end
      ttw_pkg::ST_ROW: begin
        state_next = ttw_pkg::ST_READ;
      end
      ttw_pkg::ST_READ: begin
        if (out_free) begin
          state_next = ttw_pkg::ST_IDLE;
        end
      end
      default: state_next = ttw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == ttw_pkg::ST_IDLE) && head_valid;
    div_start = pop && is_start;
    out_load  = (state == ttw_pkg::ST_READ) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ttw_pkg::ST_IDLE;
      scan_busy        <= 1'b0;
      scan_x           <= '0;
      scan_y           <= '0;
      source_column    <= '0;
      source_row       <= '0;
      column_remainder <= '0;
      row_remainder    <= '0;
      row_base         <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (is_start) begin
          scan_busy        <= 1'b1;
          scan_x           <= '0;
          scan_y           <= '0;
          source_column    <= '0;
          source_row       <= '0;
          column_remainder <= '0;
          row_remainder    <= '0;
          row_base         <= '0;
        end else if (scan_busy) begin
          if (fin) begin
            scan_busy <= 1'b0;
          end else if (end_row) begin
            scan_x           <= '0;
            source_column    <= '0;
            column_remainder <= '0;
            scan_y           <= scan_y + 1'b1;
            source_row       <= row_adv[CB+RB-1:RB];
            row_remainder    <= row_adv[RB-1:0];
          end else begin
            scan_x           <= scan_x + 1'b1;
            source_column    <= col_adv[CB+RB-1:RB];
            column_remainder <= col_adv[RB-1:0];
          end
        end
      end
      if (state == ttw_pkg::ST_ROW) begin
        row_base <= ttw_pkg::INDEX_BITS'(product);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_start || !scan_busy) begin
        hold_write  <= 1'b0;
        hold_addr   <= '0;
        hold_value  <= '0;
        hold_last   <= 1'b0;
        hold_noread <= !is_start;
      end else begin
        hold_write  <= 1'b1;
        hold_addr   <= pix_addr;
        hold_value  <= need ? head.texel : cfg.background;
        hold_last   <= fin;
        hold_noread <= fin;
      end
    end
    if (out_load) begin
      out_write <= hold_write;
      out_addr  <= hold_addr;
      out_value <= hold_value;
      out_last  <= hold_last;
      out_read  <= read_ok;
      out_index <= read_ok ? row_base + ttw_pkg::INDEX_BITS'(read_col) : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{ttw_pkg::OUT_PAD_BITS{1'b0}}, out_index, out_value, out_addr};
  assign m_tuser  = {out_read, out_write};
  assign m_tlast  = out_last;

endmodule
